[hdl/mfr_pkg.sv]
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared types, codes and helpers for the monochrome frame store block.
// ----------------------------------------------------------------------------
package mfr_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int ROWS_DEF    = 64;

    typedef enum logic [2:0] {
        REQ_FILL   = 3'd0,
        REQ_CLEAR  = 3'd1,
        REQ_INVERT = 3'd2,
        REQ_PIXEL  = 3'd3,
        REQ_READ   = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_CLR = 2'd1,
        OP_INV = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RECT,
        ST_READ,
        ST_RWAIT
    } t_state;

    typedef struct packed {
        logic load;      // capture request fields
        logic step;      // walk one byte of the rectangle
        logic rd;        // read the addressed byte
        logic out_load;  // move read data into the output register
        logic clr;       // write one zero byte of the clearing pass
    } t_cmd;

    typedef struct packed {
        logic rect_go;   // request touches at least one on-screen pixel
        logic read_ok;   // read request in range
        logic walk_last; // current step is the last byte of the rectangle
        logic clr_last;  // clearing pass at its last byte
        logic out_free;  // output register can take a beat
    } t_sts;

    function automatic logic [7:0] bit_rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    // Rows lo..hi of a page, top row in the most significant bit.
    function automatic logic [7:0] row_mask(input logic [2:0] lo, input logic [2:0] hi);
        return (8'hff >> lo) & (8'hff << (3'd7 - hi));
    endfunction

endpackage

[hdl/mfr_ctrl.sv]
// ----------------------------------------------------------------------------
// mfr_ctrl
// Request sequencer: clearing pass, rectangle walk, byte read and result.
// ----------------------------------------------------------------------------
module mfr_ctrl
    import mfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.rect_go) begin
                        n_state = ST_RECT;
                    end else if (i_sts.read_ok) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_RECT: begin
                o_cmd.step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_RWAIT;
            end
            ST_RWAIT: begin
                // hold read data until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/mfr_datapath.sv]
// ----------------------------------------------------------------------------
// mfr_datapath
// Frame store memory, rectangle walker, read-modify-write stage and output.
// ----------------------------------------------------------------------------
module mfr_datapath
    import mfr_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_x_first,
    input  logic [7:0] i_y_first,
    input  logic [7:0] i_x_second,
    input  logic [7:0] i_y_second,
    input  logic       i_color,
    input  logic       i_rsp_ready,
    output logic       o_rsp_valid,
    output logic [7:0] o_panel_byte
);

    localparam int PAGES  = (ROWS + 7) / 8;
    localparam int STORE  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(STORE);

    logic [7:0] mem [STORE];

    // request decode
    logic       is_one;
    logic [7:0] cx2, cy2, xl, xr, yt, yb;
    logic       empty;
    t_op        op_in;

    always_comb begin
        is_one = (i_req_type == REQ_PIXEL) || (i_req_type == REQ_READ);
        cx2    = is_one ? i_x_first : i_x_second;
        cy2    = is_one ? i_y_first : i_y_second;
        xl     = (i_x_first < cx2) ? i_x_first : cx2;
        xr     = (i_x_first < cx2) ? cx2 : i_x_first;
        yt     = (i_y_first < cy2) ? i_y_first : cy2;
        yb     = (i_y_first < cy2) ? cy2 : i_y_first;
        if ({1'b0, xr} >= 9'(COLUMNS)) begin
            xr = 8'(COLUMNS - 1);
        end
        if ({1'b0, yb} >= 9'(ROWS)) begin
            yb = 8'(ROWS - 1);
        end
        empty = ({1'b0, xl} >= 9'(COLUMNS)) || ({1'b0, yt} >= 9'(ROWS));
        case (i_req_type)
            REQ_FILL:   op_in = OP_SET;
            REQ_CLEAR:  op_in = OP_CLR;
            REQ_INVERT: op_in = OP_INV;
            REQ_PIXEL:  op_in = i_color ? OP_SET : OP_CLR;
            default:    op_in = OP_SET;
        endcase
    end

    // walker registers
    logic [7:0] r_x, r_xl, r_xr;
    logic [4:0] r_p, r_pt, r_pb;
    logic [2:0] r_ylo, r_yhi;
    t_op        r_op;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xl  <= xl;
            r_xr  <= xr;
            r_pt  <= yt[7:3];
            r_pb  <= yb[7:3];
            r_ylo <= yt[2:0];
            r_yhi <= yb[2:0];
            r_op  <= op_in;
            r_x   <= is_one ? i_x_first : xl;
            r_p   <= (i_req_type == REQ_READ) ? i_y_first[4:0] : yt[7:3];
        end else if (i_cmd.step) begin
            if (r_p == r_pb) begin
                r_p <= r_pt;
                r_x <= r_x + 8'd1;
            end else begin
                r_p <= r_p + 5'd1;
            end
        end
    end

    logic [ADDR_W-1:0] walk_addr;
    logic [7:0]        step_mask;

    assign walk_addr = ADDR_W'(int'(r_x) * PAGES + int'(r_p));
    assign step_mask = row_mask((r_p == r_pt) ? r_ylo : 3'd0,
                                (r_p == r_pb) ? r_yhi : 3'd7);

    // read-modify-write stage
    logic              r_wv;
    logic [ADDR_W-1:0] r_waddr;
    logic [7:0]        r_wmask;
    logic [7:0]        r_rdata;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv       <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            r_wv <= i_cmd.step;
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_waddr <= walk_addr;
            r_wmask <= step_mask;
        end
    end

    logic [7:0]        mod_data;
    logic              w_en;
    logic [ADDR_W-1:0] w_addr;
    logic [7:0]        w_data;

    always_comb begin
        case (r_op)
            OP_SET:  mod_data = r_rdata | r_wmask;
            OP_CLR:  mod_data = r_rdata & ~r_wmask;
            OP_INV:  mod_data = r_rdata ^ r_wmask;
            default: mod_data = r_rdata;
        endcase
        w_en   = i_cmd.clr | r_wv;
        w_addr = i_cmd.clr ? r_clr_addr : r_waddr;
        w_data = i_cmd.clr ? 8'h00 : mod_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (i_cmd.step || i_cmd.rd) begin
            r_rdata <= mem[walk_addr];
        end
    end

    // output register
    logic       r_ov;
    logic [7:0] r_panel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_rsp_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_panel <= bit_rev8(r_rdata);
        end
    end

    assign o_rsp_valid  = r_ov;
    assign o_panel_byte = r_panel;

    always_comb begin
        o_sts.rect_go   = (i_req_type <= REQ_PIXEL) && !empty;
        o_sts.read_ok   = (i_req_type == REQ_READ) && ({1'b0, i_x_first} < 9'(COLUMNS))
                          && ({1'b0, i_y_first} < 9'(PAGES));
        o_sts.walk_last = (r_x == r_xr) && (r_p == r_pb);
        o_sts.clr_last  = (r_clr_addr == ADDR_W'(STORE - 1));
        o_sts.out_free  = !r_ov || i_rsp_ready;
    end

endmodule

[hdl/mono_framebuffer_rect_raster_ops.sv]
// ----------------------------------------------------------------------------
// mono_framebuffer_rect_raster_ops
// Monochrome page frame store with fill, clear, invert, pixel write and read.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  req      in         i_req_valid / o_req_ready   type, corners, color
//  rsp      out        o_rsp_valid / i_rsp_ready   panel_byte
//
//  A rectangle walks one store byte per cycle, read and write overlapped
//  through a single-port-write memory. After reset a clearing pass writes
//  COLUMNS x ceil(ROWS/8) zero bytes with o_req_ready low. A stalled result
//  holds in the output register; writes keep being taken.
// ----------------------------------------------------------------------------
module mono_framebuffer_rect_raster_ops
    import mfr_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_x_first,
    input  logic [7:0] i_y_first,
    input  logic [7:0] i_x_second,
    input  logic [7:0] i_y_second,
    input  logic       i_color,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    output logic [7:0] o_panel_byte
);

    t_cmd cmd;
    t_sts sts;

    mfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mfr_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req_type),
        .i_x_first    (i_x_first),
        .i_y_first    (i_y_first),
        .i_x_second   (i_x_second),
        .i_y_second   (i_y_second),
        .i_color      (i_color),
        .i_rsp_ready  (i_rsp_ready),
        .o_rsp_valid  (o_rsp_valid),
        .o_panel_byte (o_panel_byte)
    );

endmodule
